// ----- rtl/core/psc_pkg.sv -----
// Shared types, codes and constants of the per-ID packet statistics counters.
`default_nettype none
package psc_pkg;

  localparam int NUM_IDS_DEF      = 256;
  localparam int COUNTER_BITS_DEF = 64;
  localparam int NF               = 5;
  localparam int ID_BITS_MAX      = 12;
  localparam int Q_DEPTH          = 2;

  localparam logic [2:0] OP_IN     = 3'd0;
  localparam logic [2:0] OP_OUT    = 3'd1;
  localparam logic [2:0] OP_REJECT = 3'd2;
  localparam logic [2:0] OP_HANDLE = 3'd3;
  localparam logic [2:0] OP_FBEGIN = 3'd4;
  localparam logic [2:0] OP_FEND   = 3'd5;
  localparam logic [2:0] OP_PULSE  = 3'd6;
  localparam logic [2:0] OP_READ   = 3'd7;

  localparam logic [2:0] SET_GLOBAL = 3'd6;
  localparam logic [2:0] SET_LAST_IN  = 3'd4;
  localparam logic [2:0] SET_LAST_OUT = 3'd5;

  localparam logic [2:0] FLD_COUNT  = 3'd0;
  localparam logic [2:0] FLD_BYTES  = 3'd1;
  localparam logic [2:0] FLD_REJECT = 3'd2;
  localparam logic [2:0] FLD_HSUM   = 3'd3;
  localparam logic [2:0] FLD_HMAX   = 3'd4;

  localparam logic [2:0] GF_LAST_FRAMES = 3'd0;
  localparam logic [2:0] GF_LAST_FSUM   = 3'd1;
  localparam logic [2:0] GF_LAST_FMAX   = 3'd2;
  localparam logic [2:0] GF_WIN_LEN     = 3'd3;
  localparam logic [2:0] GF_CUR_FRAMES  = 3'd4;
  localparam logic [2:0] GF_CUR_FSUM    = 3'd5;
  localparam logic [2:0] GF_CUR_FMAX    = 3'd6;

  localparam logic [3:0] ADDR_WIN_LEN = 4'h0;
  localparam logic [3:0] ADDR_MIN_WIN = 4'h8;

  localparam logic [39:0] WIN_LEN_RST = 40'd1000000000;
  localparam logic [39:0] MIN_WIN_RST = 40'd1000000;
  localparam logic [63:0] LWL_RST     = 64'd1000000000;

  typedef enum logic [2:0] {
    CMD_PKT, CMD_REJ, CMD_HND, CMD_FBEGIN, CMD_FEND, CMD_PULSE, CMD_READ, CMD_NOP
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e               kind;
    logic                    dir;
    logic                    last;
    logic                    id_ok;
    logic [ID_BITS_MAX-1:0]  id;
    logic [31:0]             val;
    logic [63:0]             now;
    logic [2:0]              set;
    logic [2:0]              fld;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage
`default_nettype wire

// ----- rtl/core/psc_queue.sv -----
// Short command queue between the front and back parts.
`default_nettype none
module psc_queue import psc_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_i,
  input  cmd_t    push_cmd_i,
  input  logic    pop_i,
  output cmd_t    head_o,
  output q_stat_t stat_o
);
  localparam int PW = $clog2(Q_DEPTH);
  localparam int CNTW = $clog2(Q_DEPTH + 1);

  cmd_t             mem_q [Q_DEPTH];
  logic [PW-1:0]    wp_q, wp_d, rp_q, rp_d;
  logic [CNTW-1:0]  cnt_q, cnt_d;

  assign stat_o.full  = (cnt_q == CNTW'(Q_DEPTH));
  assign stat_o.empty = (cnt_q == '0);
  assign head_o = mem_q[rp_q];

  always_comb begin
    wp_d  = push_i ? wp_q + 1'b1 : wp_q;
    rp_d  = pop_i ? rp_q + 1'b1 : rp_q;
    cnt_d = cnt_q + CNTW'(push_i) - CNTW'(pop_i);
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wp_q] <= push_cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      wp_q  <= wp_d;
      rp_q  <= rp_d;
      cnt_q <= cnt_d;
    end
  end
endmodule
`default_nettype wire

// ----- rtl/core/psc_front.sv -----
// Input side: accepts transactions and turns them into queued commands.
`default_nettype none
module psc_front import psc_pkg::*; #(
  parameter int NUM_IDS = NUM_IDS_DEF
) (
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [2:0]  op_i,
  input  logic [7:0]  pkt_id_i,
  input  logic [31:0] byte_count_i,
  input  logic [31:0] handler_ns_i,
  input  logic [63:0] now_ns_i,
  input  logic [2:0]  counter_set_i,
  input  logic [2:0]  counter_field_i,
  input  q_stat_t     q_stat_i,
  input  logic        clr_busy_i,
  output logic        push_o,
  output cmd_t        cmd_o
);
  logic id_ok;

  assign id_ok = (32'(pkt_id_i) < NUM_IDS);
  assign in_ready_o = !q_stat_i.full && !clr_busy_i;

  always_comb begin
    cmd_o       = '0;
    cmd_o.id_ok = id_ok;
    cmd_o.id    = ID_BITS_MAX'(pkt_id_i);
    cmd_o.now   = now_ns_i;
    cmd_o.set   = counter_set_i;
    cmd_o.fld   = counter_field_i;
    unique case (op_i)
      OP_IN, OP_OUT: begin
        cmd_o.kind = id_ok ? CMD_PKT : CMD_NOP;
        cmd_o.dir  = op_i[0];
        cmd_o.val  = byte_count_i;
      end
      OP_REJECT: begin
        cmd_o.kind = id_ok ? CMD_REJ : CMD_NOP;
      end
      OP_HANDLE: begin
        cmd_o.kind = id_ok ? CMD_HND : CMD_NOP;
        cmd_o.val  = handler_ns_i;
      end
      OP_FBEGIN: cmd_o.kind = CMD_FBEGIN;
      OP_FEND:   cmd_o.kind = CMD_FEND;
      OP_PULSE:  cmd_o.kind = CMD_PULSE;
      OP_READ: begin
        cmd_o.kind = CMD_READ;
        cmd_o.dir  = counter_set_i[0];
        cmd_o.last = (counter_set_i == SET_LAST_IN) || (counter_set_i == SET_LAST_OUT);
      end
      default: cmd_o.kind = CMD_NOP;
    endcase
  end

  assign push_o = in_valid_i && in_ready_o && (cmd_o.kind != CMD_NOP);
endmodule
`default_nettype wire

// ----- rtl/core/psc_back.sv -----
// Execution side: counter memories, window swap, frame statistics and read port.
`default_nettype none
module psc_back import psc_pkg::*; #(
  parameter int NUM_IDS      = NUM_IDS_DEF,
  parameter int COUNTER_BITS = COUNTER_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  q_stat_t     q_stat_i,
  input  cmd_t        head_i,
  output logic        pop_o,
  output logic        clr_busy_o,
  input  logic [39:0] win_len_i,
  input  logic [39:0] min_win_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [63:0] read_value_o
);
  localparam int CW  = COUNTER_BITS;
  localparam int IW  = (NUM_IDS > 1) ? $clog2(NUM_IDS) : 1;
  localparam int NP  = 1 << IW;
  localparam int TAW = IW + 1;
  localparam int BAW = IW + 2;
  localparam int RW  = NF * CW;

  typedef enum logic [3:0] {
    ST_CLEAR = 4'b0001,
    ST_IDLE  = 4'b0010,
    ST_READ  = 4'b0100,
    ST_EXEC  = 4'b1000
  } state_e;

  state_e state_q, state_d;
  logic [BAW-1:0] clr_q, clr_d;
  cmd_t cmd_q;

  logic [RW-1:0] tot_mem  [2*NP];
  logic [RW-1:0] bank_mem [4*NP];
  logic [63:0]   tag_mem  [4*NP];
  logic [RW-1:0] tot_rd_q, bank_rd_q;
  logic [63:0]   tag_rd_q;

  logic [TAW-1:0] tot_a;
  logic [BAW-1:0] bank_a;
  logic           tot_we, bank_we;
  logic [RW-1:0]  tot_wd, bank_wd;
  logic [63:0]    bank_wt;

  logic [63:0] ep_q, ep_d, wstart_q, wstart_d, fstart_q, fstart_d, lwl_q, lwl_d;
  logic        run_q, run_d;
  logic [CW-1:0] fc_q [3];
  logic [CW-1:0] fc_d [3];
  logic [CW-1:0] fl_q [3];
  logic [CW-1:0] fl_d [3];
  logic        out_valid_q, out_valid_d;
  logic [63:0] rv_q, rv_d;

  logic [CW-1:0] tot_f [NF];
  logic [CW-1:0] bank_f [NF];
  logic [CW-1:0] tot_n [NF];
  logic [CW-1:0] bank_n [NF];
  logic          tag_hit;
  logic [63:0]   tag_exp;
  logic [IW-1:0] id;
  logic          bsel;
  logic [CW-1:0] val_c;
  logic [63:0]   el_f, el_w;
  logic [CW-1:0] el_fc;
  logic [CW-1:0] nc [3];
  logic          swap;
  logic          load_out;

  assign id      = cmd_q.id[IW-1:0];
  assign bsel    = cmd_q.last ? ~ep_q[0] : ep_q[0];
  assign tag_exp = cmd_q.last ? ep_q - 64'd1 : ep_q;
  assign tag_hit = (tag_rd_q == tag_exp);
  assign val_c   = CW'(cmd_q.val);

  always_comb begin
    if (state_q == ST_CLEAR) begin
      tot_a  = clr_q[TAW-1:0];
      bank_a = clr_q;
    end else begin
      tot_a  = {cmd_q.dir, id};
      bank_a = {bsel, cmd_q.dir, id};
    end
  end

  always_comb begin
    for (int f = 0; f < NF; f++) begin
      tot_f[f]  = tot_rd_q[f*CW +: CW];
      bank_f[f] = tag_hit ? bank_rd_q[f*CW +: CW] : '0;
    end
    tot_n  = tot_f;
    bank_n = bank_f;
    priority case (cmd_q.kind)
      CMD_PKT: begin
        tot_n[FLD_COUNT]  = tot_f[FLD_COUNT] + CW'(1);
        bank_n[FLD_COUNT] = bank_f[FLD_COUNT] + CW'(1);
        tot_n[FLD_BYTES]  = tot_f[FLD_BYTES] + val_c;
        bank_n[FLD_BYTES] = bank_f[FLD_BYTES] + val_c;
      end
      CMD_REJ: begin
        tot_n[FLD_REJECT]  = tot_f[FLD_REJECT] + CW'(1);
        bank_n[FLD_REJECT] = bank_f[FLD_REJECT] + CW'(1);
      end
      CMD_HND: begin
        tot_n[FLD_HSUM]  = tot_f[FLD_HSUM] + val_c;
        bank_n[FLD_HSUM] = bank_f[FLD_HSUM] + val_c;
        if (val_c > tot_f[FLD_HMAX]) begin
          tot_n[FLD_HMAX] = val_c;
        end
        if (val_c > bank_f[FLD_HMAX]) begin
          bank_n[FLD_HMAX] = val_c;
        end
      end
      default: begin
      end
    endcase
    for (int f = 0; f < NF; f++) begin
      tot_wd[f*CW +: CW]  = tot_n[f];
      bank_wd[f*CW +: CW] = bank_n[f];
    end
    if (state_q == ST_CLEAR) begin
      tot_wd  = '0;
      bank_wd = '0;
    end
  end

  assign bank_wt = (state_q == ST_CLEAR) ? 64'd0 : ep_q;
  assign tot_we  = (state_q == ST_CLEAR) ||
                   ((state_q == ST_EXEC) &&
                    ((cmd_q.kind == CMD_PKT) || (cmd_q.kind == CMD_REJ) ||
                     (cmd_q.kind == CMD_HND)));
  assign bank_we = tot_we;

  always_ff @(posedge clk_i) begin
    if (tot_we) begin
      tot_mem[tot_a] <= tot_wd;
    end
    if (bank_we) begin
      bank_mem[bank_a] <= bank_wd;
      tag_mem[bank_a]  <= bank_wt;
    end
    tot_rd_q  <= tot_mem[tot_a];
    bank_rd_q <= bank_mem[bank_a];
    tag_rd_q  <= tag_mem[bank_a];
  end

  assign el_f  = cmd_q.now - fstart_q;
  assign el_fc = CW'(el_f);
  assign el_w  = cmd_q.now - wstart_q;

  always_comb begin
    nc = fc_q;
    if ((cmd_q.kind == CMD_FEND) && run_q) begin
      nc[0] = fc_q[0] + CW'(1);
      nc[1] = fc_q[1] + el_fc;
      if (el_fc > fc_q[2]) begin
        nc[2] = el_fc;
      end
    end
  end

  assign swap = ((cmd_q.kind == CMD_FEND) || (cmd_q.kind == CMD_PULSE)) &&
                (el_w >= {24'd0, win_len_i});

  always_comb begin
    rv_d = '0;
    if (cmd_q.set == SET_GLOBAL) begin
      unique case (cmd_q.fld)
        GF_LAST_FRAMES: rv_d = 64'(fl_q[0]);
        GF_LAST_FSUM:   rv_d = 64'(fl_q[1]);
        GF_LAST_FMAX:   rv_d = 64'(fl_q[2]);
        GF_WIN_LEN:     rv_d = lwl_q;
        GF_CUR_FRAMES:  rv_d = 64'(fc_q[0]);
        GF_CUR_FSUM:    rv_d = 64'(fc_q[1]);
        GF_CUR_FMAX:    rv_d = 64'(fc_q[2]);
        default:        rv_d = '0;
      endcase
    end else if ((cmd_q.set < SET_GLOBAL) && (cmd_q.fld <= FLD_HMAX) && cmd_q.id_ok) begin
      if (cmd_q.set < 3'd2) begin
        rv_d = 64'(tot_f[cmd_q.fld]);
      end else begin
        rv_d = 64'(bank_f[cmd_q.fld]);
      end
    end
  end

  assign load_out = (state_q == ST_EXEC) && (cmd_q.kind == CMD_READ) &&
                    (!out_valid_q || out_ready_i);
  assign out_valid_d = (out_valid_q && !out_ready_i) || load_out;

  always_comb begin
    state_d  = state_q;
    clr_d    = clr_q;
    pop_o    = 1'b0;
    ep_d     = ep_q;
    wstart_d = wstart_q;
    fstart_d = fstart_q;
    lwl_d    = lwl_q;
    run_d    = run_q;
    fc_d     = fc_q;
    fl_d     = fl_q;
    unique case (state_q)
      ST_CLEAR: begin
        clr_d = clr_q + 1'b1;
        if (clr_q == '1) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (!q_stat_i.empty) begin
          pop_o   = 1'b1;
          state_d = ST_READ;
        end
      end
      ST_READ: state_d = ST_EXEC;
      ST_EXEC: begin
        state_d = ST_IDLE;
        priority case (cmd_q.kind)
          CMD_FBEGIN: begin
            fstart_d = cmd_q.now;
            run_d    = 1'b1;
          end
          CMD_FEND, CMD_PULSE: begin
            if (cmd_q.kind == CMD_FEND) begin
              run_d = 1'b0;
            end
            if (swap) begin
              lwl_d    = (el_w < {24'd0, min_win_i}) ? {24'd0, min_win_i} : el_w;
              wstart_d = cmd_q.now;
              fl_d     = nc;
              fc_d     = '{default: '0};
              ep_d     = ep_q + 64'd1;
            end else begin
              fc_d = nc;
            end
          end
          CMD_READ: begin
            if (!load_out) begin
              state_d = ST_EXEC;
            end
          end
          default: begin
          end
        endcase
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      cmd_q <= head_i;
    end
    if (load_out) begin
      rv_q <= rv_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      ep_q        <= 64'd1;
      wstart_q    <= '0;
      fstart_q    <= '0;
      lwl_q       <= LWL_RST;
      run_q       <= 1'b0;
      fc_q        <= '{default: '0};
      fl_q        <= '{default: '0};
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      ep_q        <= ep_d;
      wstart_q    <= wstart_d;
      fstart_q    <= fstart_d;
      lwl_q       <= lwl_d;
      run_q       <= run_d;
      fc_q        <= fc_d;
      fl_q        <= fl_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign clr_busy_o   = (state_q == ST_CLEAR);
  assign out_valid_o  = out_valid_q;
  assign read_value_o = rv_q;
endmodule
`default_nettype wire

// ----- rtl/core/per_id_packet_stats_counters.sv -----
// Top level of the per-ID packet statistics counters with APB register port.
//
// Channel   Direction  Handshake               Payload
// input     in         in_valid_i/in_ready_o   op, pkt_id, byte_count, handler_ns,
//                                              now_ns, counter_set, counter_field
// output    out        out_valid_o/out_ready_i read_value
// config    in         psel/penable/pwrite     paddr, pwdata, prdata
//
// Each transaction passes the back part in order: queue pop, memory read, execute
// with write-back; the read-modify-write of the counter memories sets this order.
// After reset a clearing pass over all 4*NUM_IDS bank entries (NUM_IDS rounded up to
// a power of two) zeroes the memories; no input transaction is accepted during it, while
// register writes are taken.
// A two-entry queue lets the input side accept while the back part is busy, and
// the result register holds a read value until the output side takes it.
`default_nettype none
module per_id_packet_stats_counters import psc_pkg::*; #(
  parameter int NUM_IDS      = NUM_IDS_DEF,
  parameter int COUNTER_BITS = COUNTER_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [2:0]  op_i,
  input  logic [7:0]  pkt_id_i,
  input  logic [31:0] byte_count_i,
  input  logic [31:0] handler_ns_i,
  input  logic [63:0] now_ns_i,
  input  logic [2:0]  counter_set_i,
  input  logic [2:0]  counter_field_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [63:0] read_value_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);
  logic [39:0] win_len_q, min_win_q;
  logic        wr;
  logic        push, pop, clr_busy;
  cmd_t        push_cmd, head;
  q_stat_t     q_stat;

  assign pready = 1'b1;
  assign wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_len_q <= WIN_LEN_RST;
      min_win_q <= MIN_WIN_RST;
    end else if (wr) begin
      if (paddr[3] == ADDR_MIN_WIN[3]) begin
        min_win_q <= pwdata[39:0];
      end else begin
        win_len_q <= pwdata[39:0];
      end
    end
  end

  assign prdata = (paddr[3] == ADDR_MIN_WIN[3]) ? {24'd0, min_win_q} : {24'd0, win_len_q};

  psc_front #(.NUM_IDS(NUM_IDS)) u_front (
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .op_i            (op_i),
    .pkt_id_i        (pkt_id_i),
    .byte_count_i    (byte_count_i),
    .handler_ns_i    (handler_ns_i),
    .now_ns_i        (now_ns_i),
    .counter_set_i   (counter_set_i),
    .counter_field_i (counter_field_i),
    .q_stat_i        (q_stat),
    .clr_busy_i      (clr_busy),
    .push_o          (push),
    .cmd_o           (push_cmd)
  );

  psc_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_cmd_i (push_cmd),
    .pop_i      (pop),
    .head_o     (head),
    .stat_o     (q_stat)
  );

  psc_back #(.NUM_IDS(NUM_IDS), .COUNTER_BITS(COUNTER_BITS)) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .q_stat_i     (q_stat),
    .head_i       (head),
    .pop_o        (pop),
    .clr_busy_o   (clr_busy),
    .win_len_i    (win_len_q),
    .min_win_i    (min_win_q),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .read_value_o (read_value_o)
  );
endmodule
`default_nettype wire

// ----- dv/tb.sv -----
// Self-checking testbench for the per-ID packet statistics counters.
`default_nettype none
module tb;
  import psc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NIDS = NUM_IDS_DEF;

  typedef struct {
    logic [2:0]  op;
    logic [7:0]  pid;
    logic [31:0] bytes;
    logic [31:0] hns;
    logic [63:0] now;
    logic [2:0]  cset;
    logic [2:0]  cfld;
    bit          chk;
    logic [63:0] want;
  } stat_txn_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [2:0]  op_i = '0;
  logic [7:0]  pkt_id_i = '0;
  logic [31:0] byte_count_i = '0;
  logic [31:0] handler_ns_i = '0;
  logic [63:0] now_ns_i = '0;
  logic [2:0]  counter_set_i = '0;
  logic [2:0]  counter_field_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [63:0] read_value_o;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [63:0] pwdata = '0;
  logic [63:0] prdata;
  logic        pready;

  per_id_packet_stats_counters u_top (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Predicted state of the block.
  logic [63:0] tot_tab [2][NIDS][NF];
  logic [63:0] cur_tab [2][NIDS][NF];
  logic [63:0] last_tab [2][NIDS][NF];
  logic [63:0] fr_cur [3];
  logic [63:0] fr_last [3];
  logic [63:0] win_start, fr_start, last_win_len;
  bit          fr_run;
  logic [39:0] win_len_cfg, min_win_cfg;

  logic [63:0] reads_pending [$];
  int          n_err = 0;
  int          n_items = 0;
  int          n_reads = 0;
  int          n_swaps = 0;
  logic [63:0] sim_now = '0;
  bit          hold_go = 1'b0;

  task automatic stats_clear_cur();
    for (int d = 0; d < 2; d++)
      for (int i = 0; i < NIDS; i++)
        for (int f = 0; f < NF; f++) cur_tab[d][i][f] = '0;
    for (int f = 0; f < 3; f++) fr_cur[f] = '0;
  endtask

  task automatic window_roll(input logic [63:0] now);
    logic [63:0] el;
    el = now - win_start;
    if (el >= {24'd0, win_len_cfg}) begin
      last_win_len = (el < {24'd0, min_win_cfg}) ? {24'd0, min_win_cfg} : el;
      win_start = now;
      last_tab = cur_tab;
      fr_last = fr_cur;
      stats_clear_cur();
      n_swaps++;
    end
  endtask

  task automatic stats_apply(input stat_txn_t t, output bit has, output logic [63:0] v);
    bit ok;
    int id;
    int d;
    ok = t.pid < NIDS;
    id = t.pid;
    has = 1'b0;
    v = '0;
    case (t.op)
      OP_IN, OP_OUT: if (ok) begin
        d = (t.op == OP_OUT);
        tot_tab[d][id][FLD_COUNT] += 1;
        tot_tab[d][id][FLD_BYTES] += t.bytes;
        cur_tab[d][id][FLD_COUNT] += 1;
        cur_tab[d][id][FLD_BYTES] += t.bytes;
      end
      OP_REJECT: if (ok) begin
        tot_tab[0][id][FLD_REJECT] += 1;
        cur_tab[0][id][FLD_REJECT] += 1;
      end
      OP_HANDLE: if (ok) begin
        tot_tab[0][id][FLD_HSUM] += t.hns;
        cur_tab[0][id][FLD_HSUM] += t.hns;
        if (t.hns > tot_tab[0][id][FLD_HMAX]) tot_tab[0][id][FLD_HMAX] = t.hns;
        if (t.hns > cur_tab[0][id][FLD_HMAX]) cur_tab[0][id][FLD_HMAX] = t.hns;
      end
      OP_FBEGIN: begin
        fr_start = t.now;
        fr_run = 1'b1;
      end
      OP_FEND: begin
        if (fr_run) begin
          fr_cur[0] += 1;
          fr_cur[1] += t.now - fr_start;
          if (t.now - fr_start > fr_cur[2]) fr_cur[2] = t.now - fr_start;
          fr_run = 1'b0;
        end
        window_roll(t.now);
      end
      OP_PULSE: window_roll(t.now);
      default: begin
        has = 1'b1;
        if (t.cset == SET_GLOBAL) begin
          case (t.cfld)
            GF_LAST_FRAMES: v = fr_last[0];
            GF_LAST_FSUM:   v = fr_last[1];
            GF_LAST_FMAX:   v = fr_last[2];
            GF_WIN_LEN:     v = last_win_len;
            GF_CUR_FRAMES:  v = fr_cur[0];
            GF_CUR_FSUM:    v = fr_cur[1];
            GF_CUR_FMAX:    v = fr_cur[2];
            default:        v = '0;
          endcase
        end else if (t.cset < SET_GLOBAL && t.cfld < NF && ok) begin
          d = t.cset[0];
          if (t.cset < 2) v = tot_tab[d][id][t.cfld];
          else if (t.cset < SET_LAST_IN) v = cur_tab[d][id][t.cfld];
          else v = last_tab[d][id][t.cfld];
        end
      end
    endcase
  endtask

  // Sender: bursts of transactions separated by random gaps.
  int burst_left = 0;

  task automatic send_txn(input stat_txn_t t);
    bit acc;
    bit has;
    logic [63:0] v;
    in_valid_i <= 1'b1;
    op_i <= t.op;
    pkt_id_i <= t.pid;
    byte_count_i <= t.bytes;
    handler_ns_i <= t.hns;
    now_ns_i <= t.now;
    counter_set_i <= t.cset;
    counter_field_i <= t.cfld;
    do begin
      @(negedge clk_i);
      acc = in_ready_o;
      @(posedge clk_i);
    end while (!acc);
    stats_apply(t, has, v);
    n_items++;
    if (has) begin
      if (t.chk && v !== t.want) begin
        $error("predictor read_value expected %h got %h", t.want, v);
        n_err++;
      end
      reads_pending.insert(reads_pending.size(), v);
      n_reads++;
    end
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 24);
      if ($urandom_range(0, 2) != 0) begin
        in_valid_i <= 1'b0;
        repeat ($urandom_range(1, 9)) @(posedge clk_i);
      end
    end
  endtask

  task automatic drain_wait();
    in_valid_i <= 1'b0;
    while (reads_pending.size() != 0) @(posedge clk_i);
    repeat (16) @(posedge clk_i);
  endtask

  task automatic reg_write(input logic [3:0] addr, input logic [63:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (addr == ADDR_WIN_LEN) win_len_cfg = data[39:0];
    else min_win_cfg = data[39:0];
  endtask

  function automatic stat_txn_t rand_txn();
    stat_txn_t t;
    int r;
    r = $urandom_range(0, 99);
    t.op = (r < 22) ? OP_IN : (r < 38) ? OP_OUT : (r < 46) ? OP_REJECT :
           (r < 56) ? OP_HANDLE : (r < 62) ? OP_FBEGIN : (r < 68) ? OP_FEND :
           (r < 72) ? OP_PULSE : OP_READ;
    t.pid = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 7));
    t.bytes = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 1500);
    t.hns = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 3000);
    if ($urandom_range(0, 39) == 0) sim_now = {$urandom, $urandom};
    else sim_now += $urandom_range(0, 800);
    t.now = sim_now;
    t.cset = ($urandom_range(0, 9) == 0) ? 3'($urandom) : 3'($urandom_range(0, 6));
    t.cfld = ($urandom_range(0, 9) == 0) ? 3'($urandom) : 3'($urandom_range(0, 4));
    if (t.cset == SET_GLOBAL && $urandom_range(0, 1) == 0) t.cfld = 3'($urandom_range(0, 6));
    t.chk = 1'b0;
    t.want = '0;
    return t;
  endfunction

  // Receiver: ready pattern in modes, plus one long hold-off.
  int rmode = 0;
  int rcnt = 0;
  int hold_cnt = 0;
  bit hold_done = 1'b0;

  always @(posedge clk_i) begin
    if (rcnt == 0) begin
      rmode <= $urandom_range(0, 2);
      rcnt <= $urandom_range(20, 120);
    end else begin
      rcnt <= rcnt - 1;
    end
    if (hold_go && !hold_done) begin
      out_ready_i <= 1'b0;
      hold_cnt <= hold_cnt + 1;
      if (hold_cnt == 400) hold_done <= 1'b1;
    end else begin
      case (rmode)
        0: out_ready_i <= 1'b1;
        1: out_ready_i <= $urandom_range(0, 1);
        default: out_ready_i <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  always @(negedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (reads_pending.size() == 0) begin
        $error("read_value transaction with nothing expected: %h", read_value_o);
        n_err++;
      end else begin
        if (read_value_o !== reads_pending[0]) begin
          $error("read_value expected %h actual %h", reads_pending[0], read_value_o);
          n_err++;
        end
        void'(reads_pending.pop_front());
      end
    end
  end

  initial begin
    #20ms;
    $display("DONE: errors detected");
    $finish;
  end

  stat_txn_t dir_tab [$];

  function automatic stat_txn_t mk(input logic [2:0] op, input logic [7:0] pid,
                                   input logic [31:0] bytes, input logic [31:0] hns,
                                   input logic [63:0] now, input logic [2:0] cset,
                                   input logic [2:0] cfld, input bit chk,
                                   input logic [63:0] want);
    stat_txn_t t;
    t.op = op; t.pid = pid; t.bytes = bytes; t.hns = hns; t.now = now;
    t.cset = cset; t.cfld = cfld; t.chk = chk; t.want = want;
    return t;
  endfunction

  task automatic add_row(input stat_txn_t t);
    dir_tab.insert(dir_tab.size(), t);
  endtask

  initial begin
    logic [63:0] ones;
    ones = '1;
    for (int d = 0; d < 2; d++)
      for (int i = 0; i < NIDS; i++)
        for (int f = 0; f < NF; f++) begin
          tot_tab[d][i][f] = '0;
          last_tab[d][i][f] = '0;
        end
    stats_clear_cur();
    for (int f = 0; f < 3; f++) fr_last[f] = '0;
    win_start = '0;
    fr_start = '0;
    fr_run = 1'b0;
    last_win_len = LWL_RST;
    win_len_cfg = WIN_LEN_RST;
    min_win_cfg = MIN_WIN_RST;

    add_row(mk(OP_READ, 0, 0, 0, 0, SET_GLOBAL, GF_WIN_LEN, 1, LWL_RST));
    add_row(mk(OP_READ, 0, 0, 0, 0, 3'd0, FLD_COUNT, 1, 0));
    add_row(mk(OP_IN, 0, '1, 0, 1, 0, 0, 0, 0));
    add_row(mk(OP_IN, 0, '1, 0, 2, 0, 0, 0, 0));
    add_row(mk(OP_READ, 0, 0, 0, 3, 3'd0, FLD_BYTES, 1, 64'h1_FFFF_FFFE));
    add_row(mk(OP_OUT, 8'hFF, 0, 0, 4, 0, 0, 0, 0));
    add_row(mk(OP_READ, 8'hFF, 0, 0, 5, 3'd1, FLD_COUNT, 1, 1));
    add_row(mk(OP_REJECT, 7, 0, 0, 6, 0, 0, 0, 0));
    add_row(mk(OP_HANDLE, 7, 0, '1, 7, 0, 0, 0, 0));
    add_row(mk(OP_HANDLE, 7, 0, 5, 8, 0, 0, 0, 0));
    add_row(mk(OP_READ, 7, 0, 0, 9, 3'd2, FLD_HMAX, 1, 64'hFFFF_FFFF));
    add_row(mk(OP_READ, 7, 0, 0, 9, 3'd7, FLD_COUNT, 1, 0));
    add_row(mk(OP_READ, 0, 0, 0, 9, 3'd0, 3'd5, 1, 0));
    add_row(mk(OP_READ, 0, 0, 0, 9, SET_GLOBAL, 3'd7, 1, 0));
    add_row(mk(OP_FEND, 0, 0, 0, 100, 0, 0, 0, 0));
    add_row(mk(OP_READ, 0, 0, 0, 100, SET_GLOBAL, GF_CUR_FRAMES, 1, 0));
    add_row(mk(OP_FBEGIN, 0, 0, 0, 200, 0, 0, 0, 0));
    add_row(mk(OP_FEND, 0, 0, 0, 1200, 0, 0, 0, 0));
    add_row(mk(OP_READ, 0, 0, 0, 1200, SET_GLOBAL, GF_CUR_FSUM, 1, 1000));
    add_row(mk(OP_PULSE, 0, 0, 0, ones, 0, 0, 0, 0));
    add_row(mk(OP_READ, 0, 0, 0, ones, SET_GLOBAL, GF_WIN_LEN, 1, ones));
    add_row(mk(OP_READ, 7, 0, 0, ones, SET_LAST_IN, FLD_REJECT, 1, 1));
    add_row(mk(OP_READ, 7, 0, 0, ones, 3'd2, FLD_REJECT, 1, 0));
    add_row(mk(OP_READ, 0, 0, 0, ones, SET_GLOBAL, GF_LAST_FRAMES, 1, 1));
    add_row(mk(OP_READ, 8'hFF, 0, 0, ones, SET_LAST_OUT, FLD_COUNT, 1, 1));

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (dir_tab[i]) send_txn(dir_tab[i]);
    drain_wait();

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          reg_write(ADDR_WIN_LEN, 64'd1);
          reg_write(ADDR_MIN_WIN, 64'd1);
        end
        1: begin
          reg_write(ADDR_WIN_LEN, 64'hFF_FFFF_FFFF);
          reg_write(ADDR_MIN_WIN, 64'hFF_FFFF_FFFF);
        end
        2: begin
          reg_write(ADDR_WIN_LEN, 64'($urandom_range(500, 5000)));
          reg_write(ADDR_MIN_WIN, 64'($urandom_range(1, 3000)));
        end
        default: begin
          reg_write(ADDR_WIN_LEN, 64'd2000);
          reg_write(ADDR_MIN_WIN, 64'hAA_5555_AAAA);
        end
      endcase
      for (int k = 0; k < 150; k++) begin
        if (ph == 2 && k == 20) hold_go = 1'b1;
        send_txn(rand_txn());
      end
      drain_wait();
    end

    $display("Ran %0d transactions, %0d counter reads, %0d window swaps,", n_items,
             n_reads, n_swaps);
    $display("over five window settings including both extremes and one long output stall.");
    if (n_err == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
`default_nettype wire
